[rtl/assert_macros.svh]
// assertion macros used by the top level of the led effect sequencer
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/les_pkg.sv]
// types, codes and fixed constants of the led effect sequencer
// no dependencies; used by les_step, led_effect_sequencer, led_pattern_checker and tb
`timescale 1ns / 1ps

package les_pkg;

    localparam int NUM_LEDS     = 4;
    localparam int EFFECT_W     = 3;
    localparam int PHASE_W      = 8;
    localparam int PERIOD_REG_W = 16;
    localparam int COUNT_REG_W  = 8;
    localparam int CFG_ADDR_W   = 3;
    localparam int TDATA_IN_W   = 8;
    localparam int TDATA_OUT_W  = 8;

    // effect codes
    localparam logic [EFFECT_W-1:0] FX_OFF   = 3'd0;
    localparam logic [EFFECT_W-1:0] FX_ALL   = 3'd1;
    localparam logic [EFFECT_W-1:0] FX_PULSE = 3'd2;
    localparam logic [EFFECT_W-1:0] FX_SWEEP = 3'd3;
    localparam logic [EFFECT_W-1:0] FX_WIN   = 3'd4;
    localparam logic [EFFECT_W-1:0] FX_LOSE  = 3'd5;

    // request kinds carried on tuser
    localparam logic REQ_SELECT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_PERIOD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SWEEP_PERIOD = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WIN_PERIOD   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LOSE_PERIOD  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_WIN_COUNT    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_LOSE_COUNT   = 3'd5;

    // register reset values
    localparam logic [PERIOD_REG_W-1:0] RST_PULSE_PERIOD = 16'd300;
    localparam logic [PERIOD_REG_W-1:0] RST_SWEEP_PERIOD = 16'd150;
    localparam logic [PERIOD_REG_W-1:0] RST_WIN_PERIOD   = 16'd100;
    localparam logic [PERIOD_REG_W-1:0] RST_LOSE_PERIOD  = 16'd200;
    localparam logic [COUNT_REG_W-1:0]  RST_WIN_COUNT    = 8'd8;
    localparam logic [COUNT_REG_W-1:0]  RST_LOSE_COUNT   = 8'd6;

    localparam logic [NUM_LEDS-1:0] LEDS_ALL = 4'hF;
    localparam logic [NUM_LEDS-1:0] LEDS_OFF = 4'h0;

    typedef struct packed {
        logic [PERIOD_REG_W-1:0] pulse_period;
        logic [PERIOD_REG_W-1:0] sweep_period;
        logic [PERIOD_REG_W-1:0] win_period;
        logic [PERIOD_REG_W-1:0] lose_period;
        logic [COUNT_REG_W-1:0]  win_phase_count;
        logic [COUNT_REG_W-1:0]  lose_phase_count;
    } les_cfg_t;

    typedef struct packed {
        logic [EFFECT_W-1:0] active_effect;
        logic [PHASE_W-1:0]  phase_index;
        logic                phase_written;
        logic                effect_finished;
    } les_ctl_t;

    function automatic logic [NUM_LEDS-1:0] pattern_of(
        input logic [EFFECT_W-1:0] fx,
        input logic [PHASE_W-1:0]  ph
    );
        logic [1:0]          q;
        logic [NUM_LEDS-1:0] pat;
        q = ph[1:0];
        case (fx)
            FX_SWEEP: pat = LEDS_OFF | (4'd1 << q);
            FX_WIN:   pat = (4'd1 << q) | (4'd1 << (2'd3 - q));
            default:  pat = ph[0] ? LEDS_OFF : LEDS_ALL;
        endcase
        return pat;
    endfunction

endpackage

[rtl/les_step.sv]
// next-state and result logic for one request of the led effect sequencer
// depends on les_pkg
`timescale 1ns / 1ps

module les_step #(
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                          req_type,
    input  logic [les_pkg::EFFECT_W-1:0]  effect,
    input  les_pkg::les_cfg_t             cfg,
    input  les_pkg::les_ctl_t             ctl,
    input  logic [PERIOD_WIDTH-1:0]       ms_in_phase,
    output les_pkg::les_ctl_t             ctl_next,
    output logic [PERIOD_WIDTH-1:0]       ms_next,
    output logic                          emit,
    output logic [les_pkg::NUM_LEDS-1:0]  led_pattern
);

    localparam int CMP_W = (PERIOD_WIDTH > les_pkg::PERIOD_REG_W) ?
                           PERIOD_WIDTH : les_pkg::PERIOD_REG_W;

    logic [les_pkg::EFFECT_W-1:0]     fx_sel;
    logic [les_pkg::PERIOD_REG_W-1:0] per_raw;
    logic [les_pkg::PERIOD_REG_W-1:0] per;
    logic [PERIOD_WIDTH-1:0]          ms_inc;
    logic                             wrap;
    logic [les_pkg::PHASE_W-1:0]      ph_new;
    logic                             done;
    logic                             running;

    // unknown codes act as off
    assign fx_sel = (effect > les_pkg::FX_LOSE) ? les_pkg::FX_OFF : effect;

    always_comb
    begin
        case (ctl.active_effect)
            les_pkg::FX_PULSE: per_raw = cfg.pulse_period;
            les_pkg::FX_SWEEP: per_raw = cfg.sweep_period;
            les_pkg::FX_WIN:   per_raw = cfg.win_period;
            default:           per_raw = cfg.lose_period;
        endcase
    end

    // a zero period behaves as one
    assign per    = (per_raw == '0) ? les_pkg::PERIOD_REG_W'(1) : per_raw;
    assign ms_inc = ms_in_phase + PERIOD_WIDTH'(1);
    assign wrap   = (CMP_W'(ms_inc) >= CMP_W'(per)) || (ms_inc == '0);
    assign ph_new = wrap ? (ctl.phase_index + les_pkg::PHASE_W'(1)) : ctl.phase_index;
    assign done   = ((ctl.active_effect == les_pkg::FX_WIN) &&
                     (ph_new >= cfg.win_phase_count)) ||
                    ((ctl.active_effect == les_pkg::FX_LOSE) &&
                     (ph_new >= cfg.lose_phase_count));
    assign running = !ctl.effect_finished &&
                     (ctl.active_effect != les_pkg::FX_OFF) &&
                     (ctl.active_effect != les_pkg::FX_ALL);

    always_comb
    begin
        ctl_next    = ctl;
        ms_next     = ms_in_phase;
        emit        = 1'b0;
        led_pattern = les_pkg::LEDS_OFF;
        if (req_type == les_pkg::REQ_SELECT)
        begin
            ctl_next.active_effect   = fx_sel;
            ctl_next.phase_index     = '0;
            ctl_next.effect_finished = 1'b0;
            ms_next                  = '0;
            if ((fx_sel == les_pkg::FX_OFF) || (fx_sel == les_pkg::FX_ALL))
            begin
                ctl_next.phase_written = 1'b1;
                emit                   = 1'b1;
                led_pattern = (fx_sel == les_pkg::FX_ALL) ? les_pkg::LEDS_ALL :
                                                            les_pkg::LEDS_OFF;
            end
            else
            begin
                ctl_next.phase_written = 1'b0;
            end
        end
        else if (running)
        begin
            ms_next              = wrap ? '0 : ms_inc;
            ctl_next.phase_index = ph_new;
            if (done)
            begin
                ctl_next.effect_finished = 1'b1;
                ctl_next.phase_written   = 1'b1;
                emit                     = 1'b1;
            end
            else if (wrap || !ctl.phase_written)
            begin
                ctl_next.phase_written = 1'b1;
                emit                   = 1'b1;
                led_pattern = les_pkg::pattern_of(ctl.active_effect, ph_new);
            end
        end
    end

endmodule

[rtl/led_effect_sequencer.sv]
// top level of the four-led effect sequencer: registers, handshake and result stage
// depends on les_pkg, les_step and assert_macros.svh
//
//  channel   direction  signals                       accepted when
//  s         in         s_tvalid s_tready s_tdata      s_tvalid & s_tready
//                       s_tuser
//  m         out        m_tvalid m_tready m_tdata      m_tvalid & m_tready
//  cfg       in         cfg_we cfg_addr cfg_wdata      cfg_we
//
// one request per cycle while s_tready is high; its state update and result are formed
// in the cycle it is taken; the result shows in the next cycle from the output register
// s_tready drops only while a result sits in the output register and m_tready is low
// reset clears the state, restores register defaults and empties the output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module led_effect_sequencer #(
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [les_pkg::TDATA_IN_W-1:0]     s_tdata,   // [2:0] effect, rest zero
    input  logic [0:0]                         s_tuser,   // [0] req_type
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [les_pkg::TDATA_OUT_W-1:0]    m_tdata,   // [3:0] led_pattern, rest zero
    input  logic                               cfg_we,
    input  logic [les_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [les_pkg::PERIOD_REG_W-1:0]   cfg_wdata
);

    les_pkg::les_cfg_t              cfg_reg;
    les_pkg::les_ctl_t              ctl_reg;
    les_pkg::les_ctl_t              ctl_next;
    logic [PERIOD_WIDTH-1:0]        ms_reg;
    logic [PERIOD_WIDTH-1:0]        ms_next;
    logic                           m_tvalid_reg;
    logic [les_pkg::NUM_LEDS-1:0]   led_reg;
    logic                           emit;
    logic [les_pkg::NUM_LEDS-1:0]   led_next;
    logic                           s_fire;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(les_pkg::TDATA_OUT_W - les_pkg::NUM_LEDS){1'b0}}, led_reg};

    les_step #(
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_step (
        .req_type    (s_tuser[0]),
        .effect      (s_tdata[les_pkg::EFFECT_W-1:0]),
        .cfg         (cfg_reg),
        .ctl         (ctl_reg),
        .ms_in_phase (ms_reg),
        .ctl_next    (ctl_next),
        .ms_next     (ms_next),
        .emit        (emit),
        .led_pattern (led_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_period     <= les_pkg::RST_PULSE_PERIOD;
            cfg_reg.sweep_period     <= les_pkg::RST_SWEEP_PERIOD;
            cfg_reg.win_period       <= les_pkg::RST_WIN_PERIOD;
            cfg_reg.lose_period      <= les_pkg::RST_LOSE_PERIOD;
            cfg_reg.win_phase_count  <= les_pkg::RST_WIN_COUNT;
            cfg_reg.lose_phase_count <= les_pkg::RST_LOSE_COUNT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                les_pkg::REG_PULSE_PERIOD: cfg_reg.pulse_period <= cfg_wdata;
                les_pkg::REG_SWEEP_PERIOD: cfg_reg.sweep_period <= cfg_wdata;
                les_pkg::REG_WIN_PERIOD:   cfg_reg.win_period   <= cfg_wdata;
                les_pkg::REG_LOSE_PERIOD:  cfg_reg.lose_period  <= cfg_wdata;
                les_pkg::REG_WIN_COUNT:
                    cfg_reg.win_phase_count  <= cfg_wdata[les_pkg::COUNT_REG_W-1:0];
                les_pkg::REG_LOSE_COUNT:
                    cfg_reg.lose_phase_count <= cfg_wdata[les_pkg::COUNT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.active_effect   <= les_pkg::FX_OFF;
            ctl_reg.phase_index     <= '0;
            ctl_reg.phase_written   <= 1'b1;
            ctl_reg.effect_finished <= 1'b0;
            ms_reg                  <= '0;
            m_tvalid_reg            <= 1'b0;
        end
        else if (s_fire)
        begin
            ctl_reg      <= ctl_next;
            ms_reg       <= ms_next;
            m_tvalid_reg <= emit;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result payload, loaded with every request taken
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            led_reg <= led_next;
        end
    end

    // selecting off always shows a dark pattern next cycle
    `ASSERT_NEXT(a_off_select, clk, rst_n,
        s_fire && (s_tuser[0] == les_pkg::REQ_SELECT) &&
        (s_tdata[les_pkg::EFFECT_W-1:0] == les_pkg::FX_OFF),
        m_tvalid && (m_tdata == '0))

    // a select restarts timing
    `ASSERT_NEXT(a_select_restart, clk, rst_n,
        s_fire && (s_tuser[0] == les_pkg::REQ_SELECT),
        (ms_reg == '0) && (ctl_reg.phase_index == '0) && !ctl_reg.effect_finished)

    // a finished effect keeps its counters frozen under ticks
    `ASSERT_NEXT(a_finished_frozen, clk, rst_n,
        ctl_reg.effect_finished && s_fire && (s_tuser[0] == les_pkg::REQ_TICK),
        $stable(ms_reg) && $stable(ctl_reg.phase_index) && !m_tvalid)

    // the timing counter only runs for timed effects
    `ASSERT_SAME(a_idle_counter, clk, rst_n,
        (ctl_reg.active_effect == les_pkg::FX_OFF) ||
        (ctl_reg.active_effect == les_pkg::FX_ALL),
        (ms_reg == '0) && (ctl_reg.phase_index == '0))

endmodule

[tb/led_pattern_checker.sv]
// checker for the led effect sequencer: watches the request, result and register channels
// predicts the led pattern of each request and compares it; depends on les_pkg
`timescale 1ns / 1ps

module led_pattern_checker
    import les_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [TDATA_IN_W-1:0]   s_tdata,   // [2:0] effect, rest zero
    input  logic [0:0]              s_tuser,   // [0] req_type
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [TDATA_OUT_W-1:0]  m_tdata,   // [3:0] led_pattern, rest zero
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [PERIOD_REG_W-1:0] cfg_wdata,
    output int                      mismatches,
    output int                      outstanding
);

    les_cfg_t                regs;
    logic [EFFECT_W-1:0]     cur_effect;
    logic [PERIOD_REG_W-1:0] ms_count;
    logic [PHASE_W-1:0]      phase_no;
    logic                    phase_shown;
    logic                    effect_done;

    logic [NUM_LEDS-1:0]     pending_leds[$];
    int                      fail_count = 0;

    assign mismatches = fail_count;

    function automatic logic [NUM_LEDS-1:0] led_mask(
        input logic [EFFECT_W-1:0] fx,
        input logic [PHASE_W-1:0]  ph
    );
        logic [1:0] q;
        q = ph[1:0];
        if (fx == FX_SWEEP)
            return 4'b0001 << q;
        else if (fx == FX_WIN)
            return (4'b0001 << q) | (4'b1000 >> q);
        else
            return ph[0] ? LEDS_OFF : LEDS_ALL;
    endfunction

    task automatic advance_effect(
        input  logic                kind,
        input  logic [EFFECT_W-1:0] fx_in,
        output logic                emits,
        output logic [NUM_LEDS-1:0] leds
    );
        logic [EFFECT_W-1:0]     fx;
        logic [PERIOD_REG_W-1:0] per;
        logic [COUNT_REG_W-1:0]  phase_limit;
        emits = 1'b0;
        leds  = LEDS_OFF;
        if (kind == REQ_SELECT)
        begin
            // unknown codes behave as off
            fx = (fx_in > FX_LOSE) ? FX_OFF : fx_in;
            cur_effect  = fx;
            ms_count    = '0;
            phase_no    = '0;
            effect_done = 1'b0;
            if (fx == FX_OFF || fx == FX_ALL)
            begin
                phase_shown = 1'b1;
                emits       = 1'b1;
                leds        = (fx == FX_ALL) ? LEDS_ALL : LEDS_OFF;
            end
            else
                phase_shown = 1'b0;
        end
        else if (cur_effect >= FX_PULSE && cur_effect <= FX_LOSE && !effect_done)
        begin
            case (cur_effect)
                FX_PULSE: per = regs.pulse_period;
                FX_SWEEP: per = regs.sweep_period;
                FX_WIN:   per = regs.win_period;
                default:  per = regs.lose_period;
            endcase
            if (per == '0)
                per = PERIOD_REG_W'(1);
            ms_count = ms_count + 1'b1;
            // compared against the period in force now, so a shortened period ends the phase
            if (ms_count >= per || ms_count == '0)
            begin
                ms_count    = '0;
                phase_no    = phase_no + 1'b1;
                phase_shown = 1'b0;
            end
            phase_limit = (cur_effect == FX_WIN) ? regs.win_phase_count : regs.lose_phase_count;
            if ((cur_effect == FX_WIN || cur_effect == FX_LOSE) && phase_no >= phase_limit)
            begin
                effect_done = 1'b1;
                phase_shown = 1'b1;
                emits       = 1'b1;
                leds        = LEDS_OFF;
            end
            else if (!phase_shown)
            begin
                phase_shown = 1'b1;
                emits       = 1'b1;
                leds        = led_mask(cur_effect, phase_no);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic                emits;
        logic [NUM_LEDS-1:0] leds;
        logic [NUM_LEDS-1:0] want;
        if (!rst_n)
        begin
            regs.pulse_period     = RST_PULSE_PERIOD;
            regs.sweep_period     = RST_SWEEP_PERIOD;
            regs.win_period       = RST_WIN_PERIOD;
            regs.lose_period      = RST_LOSE_PERIOD;
            regs.win_phase_count  = RST_WIN_COUNT;
            regs.lose_phase_count = RST_LOSE_COUNT;
            cur_effect  = FX_OFF;
            ms_count    = '0;
            phase_no    = '0;
            phase_shown = 1'b1;
            effect_done = 1'b0;
            pending_leds.delete();
            outstanding <= 0;
        end
        else
        begin
            // results are registered and leave after their request is taken, so the head is always older
            if (m_tvalid && m_tready)
            begin
                if (pending_leds.size() == 0)
                begin
                    $display("%0t: led pattern expected none, got %h", $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = pending_leds.pop_front();
                    if (m_tdata !== {{(TDATA_OUT_W-NUM_LEDS){1'b0}}, want})
                    begin
                        $display("%0t: led pattern expected %h, got %h",
                                 $time, want, m_tdata);
                        fail_count++;
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_PULSE_PERIOD: regs.pulse_period     = cfg_wdata;
                    REG_SWEEP_PERIOD: regs.sweep_period     = cfg_wdata;
                    REG_WIN_PERIOD:   regs.win_period       = cfg_wdata;
                    REG_LOSE_PERIOD:  regs.lose_period      = cfg_wdata;
                    REG_WIN_COUNT:    regs.win_phase_count  = cfg_wdata[COUNT_REG_W-1:0];
                    REG_LOSE_COUNT:   regs.lose_phase_count = cfg_wdata[COUNT_REG_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                advance_effect(s_tuser[0], s_tdata[EFFECT_W-1:0], emits, leds);
                if (emits)
                    pending_leds.push_back(leds);
            end

            outstanding <= pending_leds.size();
        end
    end

endmodule

[tb/tb.sv]
// testbench top for the led effect sequencer: clock, reset, requests, register writes
// and verdict; depends on les_pkg, led_effect_sequencer and led_pattern_checker
`timescale 1ns / 1ps

module tb;
    import les_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 220;
    localparam int LONG_RUN      = 300;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd6;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [TDATA_IN_W-1:0]   s_tdata = '0;   // [2:0] effect, rest zero
    logic [0:0]              s_tuser = '0;   // [0] req_type
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0]  m_tdata;        // [3:0] led_pattern, rest zero
    logic                    cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
    logic [PERIOD_REG_W-1:0] cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int send_idle_pct = 23;
    int recv_idle_pct = 68;
    int quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    led_effect_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    led_pattern_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("led_effect_sequencer regression: fail");
            $finish;
        end
    end

    task automatic send_request(input logic kind, input logic [EFFECT_W-1:0] fx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(TDATA_IN_W-EFFECT_W){1'b0}}, fx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [EFFECT_W-1:0] any_effect();
        return EFFECT_W'($urandom_range(0, 7));
    endfunction

    // drains the result channel and gives a request with no result time to settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] pp, input logic [15:0] sp,
                                input logic [15:0] wp, input logic [15:0] lp,
                                input logic [15:0] wc, input logic [15:0] lc);
        write_reg(REG_PULSE_PERIOD, pp);
        write_reg(REG_SWEEP_PERIOD, sp);
        write_reg(REG_WIN_PERIOD, wp);
        write_reg(REG_LOSE_PERIOD, lp);
        write_reg(REG_WIN_COUNT, wc);
        write_reg(REG_LOSE_COUNT, lc);
        // unmapped index, must leave every register alone
        write_reg(REG_UNUSED + CFG_ADDR_W'($urandom_range(0, 1)), 16'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_period();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 16'($urandom_range(1, 4));
        else if (r < 75)
            return 16'd0;
        else if (r < 90)
            return 16'($urandom_range(5, 24));
        else if (r < 95)
            return 16'hFFFF;
        else
            return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return 16'($urandom_range(1, 10));
        else if (r < 85)
            return 16'd0;
        else if (r < 92)
            return 16'd255;
        else
            return 16'($urandom);
    endfunction

    initial
    begin
        int                  items;
        int                  n;
        logic [EFFECT_W-1:0] fx;
        logic                kind;
        logic [15:0]         fast;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: idle ticks, static patterns and the unknown codes
        send_request(REQ_TICK, FX_LOSE);
        send_request(REQ_SELECT, FX_ALL);
        send_request(REQ_TICK, FX_SWEEP);
        send_request(REQ_SELECT, FX_LOSE + 3'd1);
        send_request(REQ_SELECT, FX_LOSE + 3'd2);
        send_request(REQ_SELECT, FX_OFF);
        wait_idle();

        // zero period, zero win phases, longest lose period, most lose phases
        program_regs(16'd0, 16'd1, 16'd1, 16'hFFFF, 16'd0, 16'd255);
        send_request(REQ_SELECT, FX_PULSE);
        repeat (3) send_request(REQ_TICK, any_effect());
        send_request(REQ_SELECT, FX_WIN);
        send_request(REQ_TICK, any_effect());
        send_request(REQ_TICK, any_effect());
        send_request(REQ_SELECT, FX_SWEEP);
        repeat (2) send_request(REQ_TICK, any_effect());
        send_request(REQ_SELECT, FX_LOSE);
        repeat (2) send_request(REQ_TICK, any_effect());
        wait_idle();

        // lose period cut below the running count, then a one-phase win
        program_regs(16'hFFFF, 16'd1, 16'd2, 16'd1, 16'd1, 16'd255);
        send_request(REQ_TICK, any_effect());
        send_request(REQ_SELECT, FX_WIN);
        repeat (3) send_request(REQ_TICK, any_effect());

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_idle();
            case (seg / 2)
                0:
                begin
                    send_idle_pct = 23;
                    recv_idle_pct = 68;
                end
                1:
                begin
                    send_idle_pct = 68;
                    recv_idle_pct = 23;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            fast = (seg % 3 == 0) ? 16'd1 : pick_period();
            program_regs((seg % 3 == 0) ? 16'd1 : pick_period(), fast,
                         pick_period(), pick_period(), pick_count(), pick_count());

            items = 0;
            // a long run past the phase wrap of pulse and sweep
            if (seg % 3 == 0)
            begin
                send_request(REQ_SELECT, (seg == 0) ? FX_SWEEP : FX_PULSE);
                repeat (LONG_RUN) send_request(REQ_TICK, any_effect());
                items += LONG_RUN + 1;
            end

            while (items < SEGMENT_ITEMS)
            begin
                if ($urandom_range(99) < 85)
                begin
                    if ($urandom_range(99) < 85)
                        fx = FX_PULSE + EFFECT_W'($urandom_range(0, 3));
                    else
                    begin
                        n  = $urandom_range(0, 3);
                        fx = (n < 2) ? FX_OFF + EFFECT_W'(n) : FX_LOSE + EFFECT_W'(n - 1);
                    end
                    send_request(REQ_SELECT, fx);
                    n = $urandom_range(1, 30);
                    repeat (n) send_request(REQ_TICK, any_effect());
                    items += n + 1;
                end
                else
                begin
                    kind = 1'($urandom_range(0, 1));
                    send_request(kind, any_effect());
                    items++;
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("led_effect_sequencer regression: pass");
        else
            $display("led_effect_sequencer regression: fail");
        $finish;
    end

endmodule
